[rtl/smii_pkg.sv]
// ----------------------------------------------------------------------------
// smii_pkg
// Shared types and helpers of the steering map inverse interpolator.
// ----------------------------------------------------------------------------
package smii_pkg;

   localparam int PROD_W = 34;
   localparam int DEN_W  = 17;
   localparam int QUOT_W = 34;

   typedef enum logic [1:0] {
      REQ_QUERY     = 2'd0,
      REQ_WR_ANGLE  = 2'd1,
      REQ_WR_OUTPUT = 2'd2,
      REQ_WR_CELL   = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic                     start;
      logic signed [PROD_W-1:0] num;
      logic signed [DEN_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [QUOT_W-1:0] quot;
   } div_rsp_type;

   function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
      logic signed [15:0] r;
      if (v > 36'sd32767) r = 16'sh7fff;
      else if (v < -36'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

endpackage

[rtl/steer_map_inverse_interpolator.sv]
// ----------------------------------------------------------------------------
// steer_map_inverse_interpolator
// Steering map: angle axis, output axis and rate grid in on-chip memories;
// a query interpolates each row at the clamped angle, then maps rate back
// to drive output.
// ----------------------------------------------------------------------------
// Load transactions (angle axis, output axis, map cell) are accepted in the idle state.
// A query works one item at a time. It is paced by the shared divider, used at
// most once for each of the no active map rows and once for the final output,
// and by the one-read-per-cycle memory ports during the segment scans over the
// na active angle and no active output points.
// ----------------------------------------------------------------------------
module steer_map_inverse_interpolator #(
   parameter int MAX_ANGLE_POINTS  = 16,
   parameter int MAX_OUTPUT_POINTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // row_index[3:0], col_index[7:4], write_value[23:8], steer_angle[39:24],
   // target_rate[55:40]
   input  logic [55:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // drive_output[15:0]
   output logic [15:0] rsp_tdata,
   // angle_clamped[0], rate_clamped[1]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);

   localparam int AIW  = $clog2(MAX_ANGLE_POINTS);
   localparam int OIW  = $clog2(MAX_OUTPUT_POINTS);
   localparam int GD   = MAX_ANGLE_POINTS * MAX_OUTPUT_POINTS;
   localparam int GW   = $clog2(GD);
   localparam int MAXP = (MAX_ANGLE_POINTS > MAX_OUTPUT_POINTS) ?
                         MAX_ANGLE_POINTS : MAX_OUTPUT_POINTS;
   localparam int NW   = $clog2(MAXP + 1);
   localparam int SW   = (AIW > OIW) ? AIW : OIW;
   localparam int SATW = 8;

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_LO    = 16'h0002,
      S_HI    = 16'h0004,
      S_ASCAN = 16'h0008,
      S_G0    = 16'h0010,
      S_G1    = 16'h0020,
      S_G2    = 16'h0040,
      S_MUL   = 16'h0080,
      S_DIVST = 16'h0100,
      S_DIVW  = 16'h0200,
      S_FIN   = 16'h0400,
      S_F1    = 16'h0800,
      S_F2    = 16'h1000,
      S_RSCAN = 16'h2000,
      S_O1    = 16'h4000,
      S_O2    = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   logic [NW-1:0] na_ff, na_in, no_ff, no_in;
   logic signed [15:0] ang_ff, ang_in, rate_ff, rate_in;
   logic signed [15:0] x_ff, x_in, k0_ff, k0_in, k1_ff, k1_in;
   logic signed [15:0] v0_ff, v0_in, v1_ff, v1_in;
   logic signed [15:0] lo_ff, lo_in, first_ff, first_in, res_ff, res_in;
   logic [SW-1:0]  seg_ff, seg_in;
   logic [OIW-1:0] row_ff, row_in;
   logic           phase_ff, phase_in;
   logic           ac_ff, ac_in, rc_ff, rc_in;
   logic signed [smii_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [smii_pkg::DEN_W-1:0]  dk_ff, dk_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [15:0]    rsp_data_ff, rsp_data_in;
   logic [1:0]     rsp_user_ff, rsp_user_in;

   logic signed [15:0] a_mem [MAX_ANGLE_POINTS];
   logic signed [15:0] o_mem [MAX_OUTPUT_POINTS];
   logic signed [15:0] g_mem [GD];
   logic signed [15:0] r_mem [MAX_OUTPUT_POINTS];
   logic signed [15:0] a_rdata_ff, o_rdata_ff, g_rdata_ff, r_rdata_ff;
   logic [AIW-1:0] a_raddr, a_waddr;
   logic [OIW-1:0] o_raddr, o_waddr, r_raddr;
   logic [GW-1:0]  g_raddr, g_waddr, g_row_base;
   logic           a_we, o_we, g_we, r_we;

   smii_pkg::div_req_type div_req;
   smii_pkg::div_rsp_type div_rsp;

   logic [3:0]  f_row, f_col;
   logic signed [15:0] f_wv, f_ang, f_rate;
   smii_pkg::req_kind_type f_kind;
   logic        req_acc;
   logic [SATW-1:0] cw;
   logic [NW-1:0] cnt_sat_a, cnt_sat_o;
   logic signed [smii_pkg::DEN_W-1:0] dv, dx;
   logic          scan_more_a, scan_more_r;

   assign f_row  = req_tdata[3:0];
   assign f_col  = req_tdata[7:4];
   assign f_wv   = req_tdata[23:8];
   assign f_ang  = req_tdata[39:24];
   assign f_rate = req_tdata[55:40];
   assign f_kind = smii_pkg::req_kind_type'(req_tuser);

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // register count saturation into [2, max]
   always_comb begin
      cw = SATW'(csr_wdata);
      if (cw < SATW'(2)) cnt_sat_a = NW'(2);
      else if (cw > SATW'(MAX_ANGLE_POINTS)) cnt_sat_a = NW'(MAX_ANGLE_POINTS);
      else cnt_sat_a = NW'(cw);
      if (cw < SATW'(2)) cnt_sat_o = NW'(2);
      else if (cw > SATW'(MAX_OUTPUT_POINTS)) cnt_sat_o = NW'(MAX_OUTPUT_POINTS);
      else cnt_sat_o = NW'(cw);
   end

   assign g_row_base = GW'(GW'(row_ff) * GW'(MAX_ANGLE_POINTS));

   assign a_we    = req_acc && (f_kind == smii_pkg::REQ_WR_ANGLE) &&
                    (32'(f_col) < MAX_ANGLE_POINTS);
   assign o_we    = req_acc && (f_kind == smii_pkg::REQ_WR_OUTPUT) &&
                    (32'(f_row) < MAX_OUTPUT_POINTS);
   assign g_we    = req_acc && (f_kind == smii_pkg::REQ_WR_CELL) &&
                    (32'(f_col) < MAX_ANGLE_POINTS) &&
                    (32'(f_row) < MAX_OUTPUT_POINTS);
   assign a_waddr = AIW'(f_col);
   assign o_waddr = OIW'(f_row);
   assign g_waddr = GW'(GW'(f_row) * GW'(MAX_ANGLE_POINTS)) + GW'(f_col);

   assign scan_more_a = ((NW+1)'(seg_ff) + (NW+1)'(2) < (NW+1)'(na_ff)) &&
                        (a_rdata_ff < x_ff);
   assign scan_more_r = ((NW+1)'(seg_ff) + (NW+1)'(2) < (NW+1)'(no_ff)) &&
                        (r_rdata_ff < x_ff);

   assign dv = smii_pkg::DEN_W'(v1_ff) - smii_pkg::DEN_W'(v0_ff);
   assign dx = smii_pkg::DEN_W'(x_ff) - smii_pkg::DEN_W'(k0_ff);

   always_comb begin
      state_in     = state_ff;
      na_in        = na_ff;
      no_in        = no_ff;
      ang_in       = ang_ff;
      rate_in      = rate_ff;
      x_in         = x_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      lo_in        = lo_ff;
      first_in     = first_ff;
      res_in       = res_ff;
      seg_in       = seg_ff;
      row_in       = row_ff;
      phase_in     = phase_ff;
      ac_in        = ac_ff;
      rc_in        = rc_ff;
      prod_in      = prod_ff;
      dk_in        = dk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      a_raddr      = '0;
      o_raddr      = '0;
      r_raddr      = '0;
      g_raddr      = g_row_base + GW'(seg_ff);
      r_we         = 1'b0;
      div_req      = '0;
      div_req.num  = prod_ff;
      div_req.den  = dk_ff;

      if (csr_we) begin
         if (csr_index == 1'b0) na_in = cnt_sat_a;
         else no_in = cnt_sat_o;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc && (f_kind == smii_pkg::REQ_QUERY)) begin
               ang_in   = f_ang;
               rate_in  = f_rate;
               state_in = S_LO;
            end
         end
         S_LO: begin
            lo_in    = a_rdata_ff;
            a_raddr  = AIW'(na_ff - NW'(1));
            state_in = S_HI;
         end
         S_HI: begin
            if (ang_ff < lo_ff) begin
               x_in  = lo_ff;
               ac_in = 1'b1;
            end else if (ang_ff > a_rdata_ff) begin
               x_in  = a_rdata_ff;
               ac_in = 1'b1;
            end else begin
               x_in  = ang_ff;
               ac_in = 1'b0;
            end
            k0_in    = lo_ff;
            seg_in   = '0;
            a_raddr  = AIW'(1);
            state_in = S_ASCAN;
         end
         S_ASCAN: begin
            if (scan_more_a) begin
               seg_in  = seg_ff + SW'(1);
               k0_in   = a_rdata_ff;
               a_raddr = AIW'(seg_ff + SW'(2));
            end else begin
               k1_in    = a_rdata_ff;
               row_in   = '0;
               state_in = S_G0;
            end
         end
         S_G0: begin
            state_in = S_G1;
         end
         S_G1: begin
            v0_in    = g_rdata_ff;
            g_raddr  = g_row_base + GW'(seg_ff) + GW'(1);
            state_in = S_G2;
         end
         S_G2: begin
            v1_in    = g_rdata_ff;
            phase_in = 1'b0;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = dv * dx;
            dk_in    = smii_pkg::DEN_W'(k1_ff) - smii_pkg::DEN_W'(k0_ff);
            state_in = S_DIVST;
         end
         S_DIVST: begin
            if (dk_ff == '0) begin
               res_in   = v0_ff;
               state_in = S_FIN;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIVW;
            end
         end
         S_DIVW: begin
            if (div_rsp.done) begin
               res_in   = smii_pkg::sat16(36'(v0_ff) + 36'(div_rsp.quot));
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!phase_ff) begin
               r_we = 1'b1;
               if (NW'(row_ff) == no_ff - NW'(1)) begin
                  state_in = S_F1;
               end else begin
                  row_in   = row_ff + OIW'(1);
                  state_in = S_G0;
               end
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_user_in  = {rc_ff, ac_ff};
               state_in     = S_IDLE;
            end
         end
         S_F1: begin
            first_in = r_rdata_ff;
            r_raddr  = OIW'(no_ff - NW'(1));
            state_in = S_F2;
         end
         S_F2: begin
            if (rate_ff < first_ff) begin
               x_in  = first_ff;
               rc_in = 1'b1;
            end else if (r_rdata_ff < rate_ff) begin
               x_in  = r_rdata_ff;
               rc_in = 1'b1;
            end else begin
               x_in  = rate_ff;
               rc_in = 1'b0;
            end
            k0_in    = first_ff;
            seg_in   = '0;
            r_raddr  = OIW'(1);
            state_in = S_RSCAN;
         end
         S_RSCAN: begin
            if (scan_more_r) begin
               seg_in  = seg_ff + SW'(1);
               k0_in   = r_rdata_ff;
               r_raddr = OIW'(seg_ff + SW'(2));
            end else begin
               k1_in    = r_rdata_ff;
               o_raddr  = OIW'(seg_ff);
               state_in = S_O1;
            end
         end
         S_O1: begin
            v0_in    = o_rdata_ff;
            o_raddr  = OIW'(seg_ff + SW'(1));
            state_in = S_O2;
         end
         S_O2: begin
            v1_in    = o_rdata_ff;
            phase_in = 1'b1;
            state_in = S_MUL;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         na_ff        <= NW'(MAX_ANGLE_POINTS < 16 ? MAX_ANGLE_POINTS : 16);
         no_ff        <= NW'(MAX_OUTPUT_POINTS < 16 ? MAX_OUTPUT_POINTS : 16);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         na_ff        <= na_in;
         no_ff        <= no_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ang_ff      <= ang_in;
      rate_ff     <= rate_in;
      x_ff        <= x_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      v0_ff       <= v0_in;
      v1_ff       <= v1_in;
      lo_ff       <= lo_in;
      first_ff    <= first_in;
      res_ff      <= res_in;
      seg_ff      <= seg_in;
      row_ff      <= row_in;
      phase_ff    <= phase_in;
      ac_ff       <= ac_in;
      rc_ff       <= rc_in;
      prod_ff     <= prod_in;
      dk_ff       <= dk_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (a_we) a_mem[a_waddr] <= f_wv;
      a_rdata_ff <= a_mem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (o_we) o_mem[o_waddr] <= f_wv;
      o_rdata_ff <= o_mem[o_raddr];
   end

   always_ff @(posedge clock) begin
      if (g_we) g_mem[g_waddr] <= f_wv;
      g_rdata_ff <= g_mem[g_raddr];
   end

   always_ff @(posedge clock) begin
      if (r_we) r_mem[row_ff] <= res_ff;
      r_rdata_ff <= r_mem[r_raddr];
   end

   smii_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_FIN))
      else $error("result raised outside final state");

   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ASCAN) |->
      ((NW+1)'(seg_ff) + (NW+1)'(2) <= (NW+1)'(na_ff)))
      else $error("angle segment past active axis");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (dk_ff != '0))
      else $error("divider started with zero key span");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && !phase_ff) |-> (NW'(row_ff) < no_ff))
      else $error("row index past active rows");
`endif

endmodule

[rtl/smii_divider.sv]
// ----------------------------------------------------------------------------
// smii_divider
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module smii_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  smii_pkg::div_req_type div_req,
   output smii_pkg::div_rsp_type div_rsp
);

   localparam int MW = smii_pkg::PROD_W - 1;
   localparam int DW = smii_pkg::DEN_W;
   localparam int CW = $clog2(MW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [MW-1:0] numm_ff, numm_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [MW-1:0] quo_ff, quo_in;
   logic          neg_ff, neg_in;
   logic          done_ff, done_in;

   logic signed [smii_pkg::PROD_W-1:0] num_abs;
   logic signed [DW-1:0]               den_abs;
   logic [DW:0]                        rem_sh;
   logic [smii_pkg::QUOT_W-1:0]        quo_ext;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      numm_in = numm_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      num_abs = div_req.num[smii_pkg::PROD_W-1] ? -div_req.num : div_req.num;
      den_abs = div_req.den[DW-1] ? -div_req.den : div_req.den;
      rem_sh  = {rem_ff[DW-1:0], numm_ff[MW-1]};
      if (busy_ff) begin
         numm_in = {numm_ff[MW-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[MW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[MW-2:0], 1'b0};
         end
         if (cnt_ff == CW'(MW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CW'(1);
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         numm_in = num_abs[MW-1:0];
         den_in  = den_abs;
         rem_in  = '0;
         quo_in  = '0;
         neg_in  = div_req.num[smii_pkg::PROD_W-1] ^ div_req.den[DW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      numm_ff <= numm_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
   end

   assign quo_ext      = {1'b0, quo_ff};
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = neg_ff ? -$signed(quo_ext) : $signed(quo_ext);

endmodule

[verif/tb_steer_map_inverse_interpolator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_steer_map_inverse_interpolator
// Loads steering maps of varied size and shape, queries them under random
// flow control on both streams, and checks every response against an
// inverse-interpolation predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb_steer_map_inverse_interpolator;

   localparam int NPTS        = 16;
   localparam int ITEM_TARGET = 1950;
   localparam int DRAIN       = 800;
   localparam int LIMIT       = 10_000_000;

   typedef struct {
      logic signed [15:0] drive;
      logic               angle_clamp;
      logic               rate_clamp;
   } map_result_type;

   class map_scoreboard;
      logic signed [15:0] angle_axis [NPTS];
      logic signed [15:0] output_axis [NPTS];
      logic signed [15:0] rate_grid [NPTS][NPTS];
      int                 na = 16;
      int                 no = 16;
      map_result_type     pending_q [$];
      int                 errors = 0;

      function void set_count(bit idx, logic [4:0] v);
         int c;
         c = (v < 2) ? 2 : (v > NPTS) ? NPTS : v;
         if (idx == 1'b0) na = c;
         else no = c;
      endfunction

      function longint interp(longint keys [NPTS], longint vals [NPTS], int n, longint x);
         int     i;
         longint dk, r;
         i = 0;
         while (i + 2 < n && keys[i+1] < x) i++;
         dk = keys[i+1] - keys[i];
         if (dk == 0) return vals[i];
         r = vals[i] + ((vals[i+1] - vals[i]) * (x - keys[i])) / dk;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return r;
      endfunction

      function void note_request(smii_pkg::req_kind_type k, logic [3:0] row,
                                 logic [3:0] col, logic signed [15:0] wv,
                                 logic signed [15:0] ang, logic signed [15:0] rt);
         longint         akeys [NPTS], cells [NPTS], rates [NPTS], outs [NPTS];
         longint         x, y, first, last;
         map_result_type e;
         case (k)
            smii_pkg::REQ_WR_ANGLE:  angle_axis[col] = wv;
            smii_pkg::REQ_WR_OUTPUT: output_axis[row] = wv;
            smii_pkg::REQ_WR_CELL:   rate_grid[row][col] = wv;
            default: begin
               e.angle_clamp = 0;
               e.rate_clamp = 0;
               for (int i = 0; i < NPTS; i++) begin
                  akeys[i] = angle_axis[i];
                  outs[i] = output_axis[i];
               end
               x = ang;
               if (x < akeys[0]) begin
                  x = akeys[0];
                  e.angle_clamp = 1;
               end else if (x > akeys[na-1]) begin
                  x = akeys[na-1];
                  e.angle_clamp = 1;
               end
               for (int r = 0; r < no; r++) begin
                  for (int c = 0; c < NPTS; c++) cells[c] = rate_grid[r][c];
                  rates[r] = interp(akeys, cells, na, x);
               end
               for (int r = no; r < NPTS; r++) rates[r] = 0;
               first = rates[0];
               last = rates[no-1];
               y = rt;
               if (y < first) begin
                  y = first;
                  e.rate_clamp = 1;
               end else if (last < y) begin
                  y = last;
                  e.rate_clamp = 1;
               end
               e.drive = 16'(interp(rates, outs, no, y));
               pending_q = {pending_q, e};
            end
         endcase
      endfunction

      function void check_result(logic [15:0] data, logic [1:0] user);
         map_result_type e;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response: data=%h user=%b", data, user);
            return;
         end
         e = pending_q.pop_front();
         if (data !== e.drive || user[0] !== e.angle_clamp || user[1] !== e.rate_clamp) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: drive exp %0d got %0d, angle_clamp exp %b got %b, ",
                         "rate_clamp exp %b got %b"},
                        e.drive, $signed(data), e.angle_clamp, user[0], e.rate_clamp,
                        user[1]);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 0;
   logic        csr_index = 0;
   logic [4:0]  csr_wdata = '0;

   map_scoreboard sb = new();
   int            items = 0;
   int            cycles = 0;
   bit            calm = 0;
   bit            hold_req = 0;

   steer_map_inverse_interpolator DUT (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: random stalls, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (reset) begin
            rsp_tready <= 0;
         end else if (hold_req) begin
            hold_req = 0;
            rsp_tready <= 0;
            repeat (3000) @(posedge clock);
            rsp_tready <= 1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_tready <= 1;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   task automatic send_req(smii_pkg::req_kind_type k, logic [3:0] row, logic [3:0] col,
                           logic signed [15:0] wv, logic signed [15:0] ang,
                           logic signed [15:0] rt);
      req_tvalid <= 1;
      req_tuser <= k;
      req_tdata <= {rt, ang, wv, col, row};
      do @(posedge clock); while (!req_tready);
      sb.note_request(k, row, col, wv, ang, rt);
      items++;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic write_count(bit idx, logic [4:0] v);
      req_tvalid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_count(idx, v);
      csr_we <= 0;
   endtask

   function automatic logic signed [15:0] clip16(longint v);
      return (v > 32767) ? 16'sh7fff : (v < -32768) ? 16'sh8000 : 16'(v);
   endfunction

   // ascending axes and a rate grid that rises (or, rarely, falls) along rows
   task automatic load_map(int n_ang, int n_out);
      longint v;
      bit     falling;
      v = -longint'($urandom_range(0, 20000));
      for (int c = 0; c < n_ang; c++) begin
         send_req(smii_pkg::REQ_WR_ANGLE, 4'($urandom), 4'(c), clip16(v), 16'($urandom),
                  16'($urandom));
         v += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4000);
      end
      v = -longint'($urandom_range(0, 20000));
      for (int r = 0; r < n_out; r++) begin
         send_req(smii_pkg::REQ_WR_OUTPUT, 4'(r), 4'($urandom), clip16(v), 16'($urandom),
                  16'($urandom));
         v += $urandom_range(0, 3000);
      end
      falling = ($urandom_range(0, 4) == 0);
      for (int c = 0; c < n_ang; c++) begin
         v = -longint'($urandom_range(0, 15000));
         for (int r = 0; r < n_out; r++) begin
            send_req(smii_pkg::REQ_WR_CELL, 4'(falling ? n_out - 1 - r : r), 4'(c),
                     clip16(v), 16'($urandom), 16'($urandom));
            v += $urandom_range(0, 3500);
         end
      end
   endtask

   task automatic run_queries(int count);
      int                 sel;
      logic signed [15:0] ang, rt;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            send_req(smii_pkg::req_kind_type'(2'($urandom)), 4'($urandom), 4'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom));
         end else if (sel == 1) begin
            send_req(smii_pkg::REQ_WR_CELL, 4'($urandom_range(0, sb.no - 1)),
                     4'($urandom_range(0, sb.na - 1)), 16'($urandom), 16'($urandom),
                     16'($urandom));
         end else begin
            ang = clip16(longint'(sb.angle_axis[$urandom_range(0, sb.na - 1)])
                         + $urandom_range(0, 3000) - 1500);
            rt = clip16(longint'(sb.rate_grid[$urandom_range(0, sb.no - 1)]
                                             [$urandom_range(0, sb.na - 1)])
                        + $urandom_range(0, 3000) - 1500);
            if ($urandom_range(0, 9) == 0) ang = 16'($urandom);
            if ($urandom_range(0, 9) == 0) rt = 16'($urandom);
            send_req(smii_pkg::REQ_QUERY, 4'($urandom), 4'($urandom), 16'($urandom), ang,
                     rt);
         end
      end
   endtask

   function automatic logic [4:0] pick_count();
      return ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 4)) : 5'($urandom);
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // every entry gets written once before the first query
      for (int c = 0; c < NPTS; c++) begin
         send_req(smii_pkg::REQ_WR_ANGLE, 4'd0, 4'(c), 16'(c * 2048 - 16384), 16'd0,
                  16'd0);
         send_req(smii_pkg::REQ_WR_OUTPUT, 4'(c), 4'd0, 16'(c * 1000 - 8000), 16'd0,
                  16'd0);
         for (int r = 0; r < NPTS; r++)
            send_req(smii_pkg::REQ_WR_CELL, 4'(r), 4'(c), 16'(r * 1500 + c * 100 - 12000),
                     16'd0, 16'd0);
      end

      // directed queries at full size
      send_req(smii_pkg::REQ_QUERY, 4'hf, 4'hf, 16'sh7fff, 16'sh8000, 16'sh8000);
      send_req(smii_pkg::REQ_QUERY, 4'h0, 4'h0, 16'sh8000, 16'sh7fff, 16'sh7fff);
      send_req(smii_pkg::REQ_QUERY, 4'h5, 4'ha, 16'h55aa, -16'sd16384, -16'sd12000);
      send_req(smii_pkg::REQ_QUERY, 4'ha, 4'h5, 16'haa55, 16'sd14336, 16'sd11000);
      send_req(smii_pkg::REQ_QUERY, 4'h3, 4'h3, 16'h0, 16'sd1000, 16'sd0);
      // equal neighboring angle keys
      send_req(smii_pkg::REQ_WR_ANGLE, 4'h0, 4'h1, -16'sd16384, 16'h0, 16'h0);
      send_req(smii_pkg::REQ_QUERY, 4'h0, 4'h0, 16'h0, -16'sd16384, 16'sd0);
      send_req(smii_pkg::REQ_QUERY, 4'h0, 4'h0, 16'h0, -16'sd15000, 16'sd500);
      // reversed rate bounds: last row below first
      send_req(smii_pkg::REQ_WR_CELL, 4'hf, 4'h8, -16'sd30000, 16'h0, 16'h0);
      send_req(smii_pkg::REQ_WR_CELL, 4'hf, 4'h9, -16'sd30000, 16'h0, 16'h0);
      send_req(smii_pkg::REQ_QUERY, 4'h0, 4'h0, 16'h0, 16'sd1000, 16'sh8000);
      send_req(smii_pkg::REQ_QUERY, 4'h0, 4'h0, 16'h0, 16'sd1000, 16'sh7fff);
      // non-ascending output axis
      send_req(smii_pkg::REQ_WR_OUTPUT, 4'h4, 4'h0, 16'sh7fff, 16'h0, 16'h0);
      send_req(smii_pkg::REQ_QUERY, 4'h0, 4'h0, 16'h0, 16'sd0, -16'sd5000);

      // count register extremes, including values that saturate
      write_count(1'b0, 5'd0);
      write_count(1'b1, 5'd31);
      run_queries(6);
      write_count(1'b0, 5'd31);
      write_count(1'b1, 5'd1);
      run_queries(6);
      write_count(1'b0, 5'd16);
      write_count(1'b1, 5'd2);
      run_queries(6);

      // sender keeps offering while the response side holds off
      hold_req = 1;
      run_queries(12);

      while (items < ITEM_TARGET) begin
         write_count(1'b0, pick_count());
         write_count(1'b1, pick_count());
         if ($urandom_range(0, 3) != 0) load_map(sb.na, sb.no);
         if (items > ITEM_TARGET - 200) calm = 1;
         run_queries($urandom_range(20, 50));
      end

      req_tvalid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/smii_pkg.sv
rtl/smii_divider.sv
rtl/steer_map_inverse_interpolator.sv
verif/tb_steer_map_inverse_interpolator.sv
